### rtl/fdfd_pkg.sv
// Shared types and constants for the frame difference flame detector.
// No dependencies; all other rtl files except fdfd_mask_ram refer to it by scoped names.
`default_nettype none

package fdfd_pkg;

  // Mask store and row geometry
  localparam int MASK_PIXELS = 2097152;
  localparam int MAX_ROWS    = 4096;
  localparam int MASK_AW     = $clog2(MASK_PIXELS);      // index into the store
  localparam int ADDR_W      = $clog2(MASK_PIXELS + 1);  // address that can reach the depth
  localparam int ROW_W       = $clog2(MAX_ROWS);

  // Register and field widths
  localparam int PIX_W    = 8;
  localparam int COUNT_W  = 22;
  localparam int FIRST_W  = 12;
  localparam int ROWCNT_W = 13;
  localparam int CMP_W    = ((ROW_W > ROWCNT_W) ? ROW_W : ROWCNT_W) + 1;

  // BT.601 luma weights in Q14
  localparam int GRAY_SUM_W = 22;
  localparam int GRAY_SHIFT = 14;
  localparam logic [GRAY_SUM_W-1:0] COEF_R  = GRAY_SUM_W'(4899);
  localparam logic [GRAY_SUM_W-1:0] COEF_G  = GRAY_SUM_W'(9617);
  localparam logic [GRAY_SUM_W-1:0] COEF_B  = GRAY_SUM_W'(1868);
  localparam logic [GRAY_SUM_W-1:0] ROUND_C = GRAY_SUM_W'(8192);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIT_MINIMUM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_MINIMUM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_FIRST_ROW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_ROW_COUNT = 3'd4;

  // Register reset values
  localparam logic [PIX_W-1:0]    RST_GRAY_THRESHOLD = 8'd50;
  localparam logic [COUNT_W-1:0]  RST_LIT_MINIMUM    = 22'd5;
  localparam logic [COUNT_W-1:0]  RST_CHANGE_MINIMUM = 22'd5;
  localparam logic [FIRST_W-1:0]  RST_BAND_FIRST_ROW = 12'd161;
  localparam logic [ROWCNT_W-1:0] RST_BAND_ROW_COUNT = 13'd753;

  // One pixel word on its way from the front stage to the judge stage
  typedef struct packed {
    logic               valid;
    logic               use_pix;    // band pixel that fits in the store
    logic               ovf;        // band pixel beyond the store
    logic               frame_end;
    logic [PIX_W-1:0]   gray;
    logic [MASK_AW-1:0] addr;
  } item_t;

  // Mask read request issued at acceptance
  typedef struct packed {
    logic               en;
    logic [MASK_AW-1:0] addr;
  } rd_req_t;

endpackage

`default_nettype wire

### rtl/fdfd_mask_ram.sv
// Generic single-bit-wide simple dual port RAM, one write and one
// registered read per cycle. No dependencies.
`default_nettype none

module fdfd_mask_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic          wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic               rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/fdfd_front.sv
// Front stage: accepts pixel words, tracks row and mask address, computes
// gray and issues the mask read. Depends on fdfd_pkg.
`default_nettype none

module fdfd_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic                         adv,
  input  wire logic [fdfd_pkg::PIX_W-1:0]   red,
  input  wire logic [fdfd_pkg::PIX_W-1:0]   green,
  input  wire logic [fdfd_pkg::PIX_W-1:0]   blue,
  input  wire logic                         line_end,
  input  wire logic                         frame_end,
  input  wire logic [fdfd_pkg::FIRST_W-1:0] band_first_row,
  input  wire logic [fdfd_pkg::ROWCNT_W-1:0] band_row_count,
  output fdfd_pkg::item_t                   item,
  output fdfd_pkg::rd_req_t                 rd_req
);

  logic [fdfd_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [fdfd_pkg::ADDR_W-1:0]     addr_r, addr_nxt;
  fdfd_pkg::item_t                 item_r, item_nxt;
  logic [fdfd_pkg::CMP_W-1:0]      row_ext, first_ext, diff;
  logic                            in_band, fits;
  logic [fdfd_pkg::GRAY_SUM_W-1:0] gray_sum;

  always_comb begin
    row_ext   = fdfd_pkg::CMP_W'(row_r);
    first_ext = fdfd_pkg::CMP_W'(band_first_row);
    diff      = row_ext - first_ext;
    in_band   = (row_ext >= first_ext) &&
                (diff < fdfd_pkg::CMP_W'(band_row_count));
    fits      = addr_r < fdfd_pkg::ADDR_W'(fdfd_pkg::MASK_PIXELS);
    gray_sum  = fdfd_pkg::GRAY_SUM_W'(red)   * fdfd_pkg::COEF_R +
                fdfd_pkg::GRAY_SUM_W'(green) * fdfd_pkg::COEF_G +
                fdfd_pkg::GRAY_SUM_W'(blue)  * fdfd_pkg::COEF_B +
                fdfd_pkg::ROUND_C;
  end

  // Row and address bookkeeping, updated only on accepted words
  always_comb begin
    row_nxt  = row_r;
    addr_nxt = addr_r;
    if (accept) begin
      if (frame_end) begin
        row_nxt  = '0;
        addr_nxt = '0;
      end else begin
        if (in_band && fits) begin
          addr_nxt = addr_r + fdfd_pkg::ADDR_W'(1);
        end
        if (line_end && (row_r < fdfd_pkg::ROW_W'(fdfd_pkg::MAX_ROWS - 1))) begin
          row_nxt = row_r + fdfd_pkg::ROW_W'(1);
        end
      end
    end
  end

  always_comb begin
    item_nxt = item_r;
    if (accept) begin
      item_nxt.valid     = 1'b1;
      item_nxt.use_pix   = in_band && fits;
      item_nxt.ovf       = in_band && !fits;
      item_nxt.frame_end = frame_end;
      item_nxt.gray      = gray_sum[fdfd_pkg::GRAY_SHIFT +: fdfd_pkg::PIX_W];
      item_nxt.addr      = addr_r[fdfd_pkg::MASK_AW-1:0];
    end else if (adv) begin
      item_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      addr_r       <= '0;
      item_r.valid <= 1'b0;
    end else begin
      row_r        <= row_nxt;
      addr_r       <= addr_nxt;
      item_r.valid <= item_nxt.valid;
    end
    item_r.use_pix   <= item_nxt.use_pix;
    item_r.ovf       <= item_nxt.ovf;
    item_r.frame_end <= item_nxt.frame_end;
    item_r.gray      <= item_nxt.gray;
    item_r.addr      <= item_nxt.addr;
  end

  assign item        = item_r;
  assign rd_req.en   = accept && in_band && fits;
  assign rd_req.addr = addr_r[fdfd_pkg::MASK_AW-1:0];

endmodule

`default_nettype wire

### rtl/fdfd_judge.sv
// Judge stage: compares each new mask bit with the stored one, keeps the
// frame counters, writes the mask back and holds the frame result.
// Depends on fdfd_pkg.
`default_nettype none

module fdfd_judge (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fdfd_pkg::item_t               item,
  input  wire fdfd_pkg::rd_req_t             rd_req,
  input  wire logic                          rd_data,
  input  wire logic [fdfd_pkg::PIX_W-1:0]    gray_threshold,
  input  wire logic [fdfd_pkg::COUNT_W-1:0]  lit_minimum,
  input  wire logic [fdfd_pkg::COUNT_W-1:0]  change_minimum,
  input  wire logic                          out_ready,
  output logic                               adv,
  output logic                               wr_en,
  output logic [fdfd_pkg::MASK_AW-1:0]       wr_addr,
  output logic                               wr_data,
  output logic                               out_valid,
  output logic                               fire_found,
  output logic [fdfd_pkg::COUNT_W-1:0]       lit_pixels,
  output logic [fdfd_pkg::COUNT_W-1:0]       changed_pixels,
  output logic                               store_overflow
);

  localparam logic [fdfd_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  logic                         retire, now, prev_bit;
  logic                         first_r, first_nxt;
  logic                         ovf_r, ovf_nxt, ovf_upd;
  logic [fdfd_pkg::COUNT_W-1:0] lit_r, lit_nxt, lit_upd;
  logic [fdfd_pkg::COUNT_W-1:0] chg_r, chg_nxt, chg_upd;
  logic                         fwd_r, fwd_bit_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         fire_r, oflow_r;
  logic [fdfd_pkg::COUNT_W-1:0] lit_out_r, chg_out_r;

  // Hold the stage only when a frame result finds the output still full
  assign adv    = !item.valid || !item.frame_end || !out_valid_r || out_ready;
  assign retire = item.valid && adv;

  assign now      = item.gray > gray_threshold;
  assign prev_bit = fwd_r ? fwd_bit_r : rd_data;

  assign wr_en   = retire && item.use_pix;
  assign wr_addr = item.addr;
  assign wr_data = now;

  always_comb begin
    lit_upd = lit_r;
    chg_upd = chg_r;
    ovf_upd = ovf_r || item.ovf;
    if (item.use_pix) begin
      if (now && (lit_r != COUNT_MAX)) begin
        lit_upd = lit_r + fdfd_pkg::COUNT_W'(1);
      end
      if (!first_r && (now != prev_bit) && (chg_r != COUNT_MAX)) begin
        chg_upd = chg_r + fdfd_pkg::COUNT_W'(1);
      end
    end
  end

  always_comb begin
    lit_nxt       = lit_r;
    chg_nxt       = chg_r;
    ovf_nxt       = ovf_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (retire) begin
      if (item.frame_end) begin
        lit_nxt       = '0;
        chg_nxt       = '0;
        ovf_nxt       = 1'b0;
        first_nxt     = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        lit_nxt = lit_upd;
        chg_nxt = chg_upd;
        ovf_nxt = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r       <= '0;
      chg_r       <= '0;
      ovf_r       <= 1'b0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      lit_r       <= lit_nxt;
      chg_r       <= chg_nxt;
      ovf_r       <= ovf_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (rd_req.en) begin
        fwd_r <= wr_en && (wr_addr == rd_req.addr);
      end
    end
  end

  // Bypass a write that lands on the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      fwd_bit_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (retire && item.frame_end) begin
      fire_r    <= !first_r && (lit_upd > lit_minimum) && (chg_upd > change_minimum);
      lit_out_r <= lit_upd;
      chg_out_r <= chg_upd;
      oflow_r   <= ovf_upd;
    end
  end

  assign out_valid      = out_valid_r;
  assign fire_found     = fire_r;
  assign lit_pixels     = lit_out_r;
  assign changed_pixels = chg_out_r;
  assign store_overflow = oflow_r;

endmodule

`default_nettype wire

### rtl/frame_difference_flame_detector_top.sv
// Frame difference flame detector: top level, configuration registers and
// mask store. Depends on fdfd_pkg, fdfd_mask_ram, fdfd_front, fdfd_judge.
//
// Pixels stream in raster order, one word per clock, and the block sustains
// one pixel per cycle. Each pixel is converted to BT.601 gray (Q14 weights)
// in the accepting cycle, while the one-bit mask store is read at the
// pixel's mask address; after the item register, the bright bit is compared
// with the previous frame's bit, the lit and changed counters are advanced
// (saturating at 2^22-1) and the new bit is written back. A read that hits
// the entry being written in the same cycle is bypassed, so even one-pixel
// frames see the bit the previous frame left. Only rows inside the band set
// by band_first_row and band_row_count are used; band pixels beyond the
// store are dropped and raise store_overflow. On the frame-end word one
// result word appears once the judge stage retires that pixel; it is held in
// an output register until taken; input is stalled only while a further
// frame-end result would find that register still full. The first frame
// after reset never reports fire. The store has MASK_PIXELS one-bit entries
// and needs no clearing pass: an entry is always written in one frame before
// the next frame reads it, as long as a frame's band never holds more pixels
// than an earlier frame since reset. Configuration is written through the
// plain write port while the block is idle; the user must ensure it, unchecked.
`default_nettype none

module frame_difference_flame_detector_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Pixel input
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [23:0]                     in_tdata,   // red, green, blue
  input  wire logic                            in_tuser,   // line_end
  input  wire logic                            in_tlast,   // frame_end
  // Frame result
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [47:0]                          out_tdata,  // lit_pixels, changed_pixels, zero pad
  output logic [1:0]                           out_tuser,  // fire_found, store_overflow
  // Configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [fdfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fdfd_pkg::COUNT_W-1:0]    cfg_wr_data
);

  logic [fdfd_pkg::PIX_W-1:0]    gray_threshold_r;
  logic [fdfd_pkg::COUNT_W-1:0]  lit_minimum_r;
  logic [fdfd_pkg::COUNT_W-1:0]  change_minimum_r;
  logic [fdfd_pkg::FIRST_W-1:0]  band_first_row_r;
  logic [fdfd_pkg::ROWCNT_W-1:0] band_row_count_r;

  logic                          accept, adv;
  fdfd_pkg::item_t               item;
  fdfd_pkg::rd_req_t             rd_req;
  logic                          rd_data;
  logic                          wr_en, wr_data;
  logic [fdfd_pkg::MASK_AW-1:0]  wr_addr;
  logic                          fire_found, store_overflow;
  logic [fdfd_pkg::COUNT_W-1:0]  lit_pixels, changed_pixels;

  // Configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_threshold_r <= fdfd_pkg::RST_GRAY_THRESHOLD;
      lit_minimum_r    <= fdfd_pkg::RST_LIT_MINIMUM;
      change_minimum_r <= fdfd_pkg::RST_CHANGE_MINIMUM;
      band_first_row_r <= fdfd_pkg::RST_BAND_FIRST_ROW;
      band_row_count_r <= fdfd_pkg::RST_BAND_ROW_COUNT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fdfd_pkg::REG_GRAY_THRESHOLD: begin
          gray_threshold_r <= cfg_wr_data[fdfd_pkg::PIX_W-1:0];
        end
        fdfd_pkg::REG_LIT_MINIMUM: begin
          lit_minimum_r <= cfg_wr_data;
        end
        fdfd_pkg::REG_CHANGE_MINIMUM: begin
          change_minimum_r <= cfg_wr_data;
        end
        fdfd_pkg::REG_BAND_FIRST_ROW: begin
          band_first_row_r <= cfg_wr_data[fdfd_pkg::FIRST_W-1:0];
        end
        fdfd_pkg::REG_BAND_ROW_COUNT: begin
          band_row_count_r <= cfg_wr_data[fdfd_pkg::ROWCNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Take a word whenever the judge stage can move on
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;

  fdfd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .adv            (adv),
    .red            (in_tdata[7:0]),
    .green          (in_tdata[15:8]),
    .blue           (in_tdata[23:16]),
    .line_end       (in_tuser),
    .frame_end      (in_tlast),
    .band_first_row (band_first_row_r),
    .band_row_count (band_row_count_r),
    .item           (item),
    .rd_req         (rd_req)
  );

  fdfd_mask_ram #(
    .DEPTH (fdfd_pkg::MASK_PIXELS),
    .AW    (fdfd_pkg::MASK_AW)
  ) u_mask_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_req.en),
    .rd_addr (rd_req.addr),
    .rd_data (rd_data)
  );

  fdfd_judge u_judge (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (item),
    .rd_req         (rd_req),
    .rd_data        (rd_data),
    .gray_threshold (gray_threshold_r),
    .lit_minimum    (lit_minimum_r),
    .change_minimum (change_minimum_r),
    .out_ready      (out_tready),
    .adv            (adv),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .out_valid      (out_tvalid),
    .fire_found     (fire_found),
    .lit_pixels     (lit_pixels),
    .changed_pixels (changed_pixels),
    .store_overflow (store_overflow)
  );

  assign out_tdata = {4'b0000, changed_pixels, lit_pixels};
  assign out_tuser = {store_overflow, fire_found};

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for frame_difference_flame_detector_top: streams RGB pixel words,
// predicts frame reports from its own copy of the mask, counters and settings.
// Depends on fdfd_pkg and the detector rtl; reads no files.
module testbench;
  import fdfd_pkg::*;

  // Cycles to let the pipeline empty after the last report before a register write
  localparam int SETTLE_CYCLES     = 6;
  // Random part stops once this many pixel words have been taken in all
  localparam int TOTAL_WORDS       = 600;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;
  localparam logic [ROW_W-1:0]   ROW_LAST    = ROW_W'(MAX_ROWS - 1);
  // Fill frame: a band block larger than any band that a later frame holds
  localparam int FILL_ROWS  = 8;
  localparam int FILL_WIDTH = 8;
  localparam int FILL_WORDS = FILL_ROWS * FILL_WIDTH;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             line_end;
    logic             frame_end;
  } pixel_t;

  typedef struct packed {
    logic               fire_found;
    logic [COUNT_W-1:0] lit_pixels;
    logic [COUNT_W-1:0] changed_pixels;
    logic               store_overflow;
  } frame_report_t;

  typedef struct {
    logic [PIX_W-1:0]    thr;
    logic [COUNT_W-1:0]  lit_min;
    logic [COUNT_W-1:0]  chg_min;
    logic [FIRST_W-1:0]  first_row;
    logic [ROWCNT_W-1:0] row_count;
  } band_cfg_t;

  // One directed word: settings group, pixel, and optionally a hand-written report
  typedef struct {
    int            seg;
    pixel_t        px;
    bit            typed;
    frame_report_t want;
  } dir_row_t;

  // DUT connections; every input starts at a known value
  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [23:0]         in_tdata    = '0;   // red, green, blue
  logic                in_tuser    = 1'b0; // line_end
  logic                in_tlast    = 1'b0; // frame_end
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [47:0]         out_tdata;          // lit_pixels, changed_pixels, zero pad
  logic [1:0]          out_tuser;          // fire_found, store_overflow
  logic                cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_GRAY_THRESHOLD;
  logic [COUNT_W-1:0]  cfg_wr_data = '0;

  // Predicted detector state
  bit                  mask_copy [MASK_PIXELS];
  bit                  first_frame_pending = 1'b1;
  logic [ROW_W-1:0]    row_now   = '0;
  int                  mask_ptr  = 0;
  logic [COUNT_W-1:0]  lit_now   = '0;
  logic [COUNT_W-1:0]  chg_now   = '0;
  bit                  ovf_now   = 1'b0;
  band_cfg_t           live_cfg  = '{RST_GRAY_THRESHOLD, RST_LIT_MINIMUM, RST_CHANGE_MINIMUM,
                                     RST_BAND_FIRST_ROW, RST_BAND_ROW_COUNT};

  // Reports owed by the block, oldest first
  frame_report_t       pending_reports [$];

  int  error_count    = 0;
  int  reports_seen   = 0;
  int  fire_reports   = 0;
  int  overflow_seen  = 0;
  int  band_words     = 0;
  int  words_sent     = 0;
  bit  sender_idles   = 1'b0;
  bit  receiver_stalls = 1'b1;
  int  stall_left     = 0;

  frame_difference_flame_detector_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic frame_report_t report(input bit fire, input int lit, input int chg,
                                           input bit ovf);
    frame_report_t r;
    r.fire_found     = fire;
    r.lit_pixels     = COUNT_W'(lit);
    r.changed_pixels = COUNT_W'(chg);
    r.store_overflow = ovf;
    return r;
  endfunction

  function automatic pixel_t pixel(input int r, input int g, input int b, input bit le,
                                   input bit fe);
    pixel_t p;
    p.red       = PIX_W'(r);
    p.green     = PIX_W'(g);
    p.blue      = PIX_W'(b);
    p.line_end  = le;
    p.frame_end = fe;
    return p;
  endfunction

  function automatic pixel_t noise_pixel(input bit le, input bit fe);
    return pixel(int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                 int'($urandom_range(0, 255)), le, fe);
  endfunction

  function automatic band_cfg_t settings(input int thr, input int lit_min, input int chg_min,
                                         input int first_row, input int row_count);
    band_cfg_t c;
    c.thr       = PIX_W'(thr);
    c.lit_min   = COUNT_W'(lit_min);
    c.chg_min   = COUNT_W'(chg_min);
    c.first_row = FIRST_W'(first_row);
    c.row_count = ROWCNT_W'(row_count);
    return c;
  endfunction

  function automatic dir_row_t dir_row(input int seg, input pixel_t px, input bit typed,
                                       input frame_report_t want);
    dir_row_t d;
    d.seg   = seg;
    d.px    = px;
    d.typed = typed;
    d.want  = want;
    return d;
  endfunction

  // Mostly short thresholds and band windows so that fire, no fire and empty bands all occur
  function automatic band_cfg_t random_settings();
    band_cfg_t c;
    int pick;
    pick = $urandom_range(0, 9);
    c.thr = (pick == 0) ? '0 : (pick == 1) ? '1 : PIX_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 19);
    c.lit_min = (pick < 14) ? COUNT_W'($urandom_range(0, 6)) :
                (pick < 17) ? '0 :
                (pick < 19) ? COUNT_W'(MASK_PIXELS) : COUNT_W'($urandom);
    pick = $urandom_range(0, 19);
    c.chg_min = (pick < 14) ? COUNT_W'($urandom_range(0, 4)) :
                (pick < 17) ? '0 :
                (pick < 19) ? COUNT_W'(MASK_PIXELS) : COUNT_W'($urandom);
    pick = $urandom_range(0, 19);
    c.first_row = (pick < 18) ? FIRST_W'($urandom_range(0, 3)) : FIRST_W'($urandom);
    pick = $urandom_range(0, 19);
    c.row_count = (pick < 2) ? '0 :
                  (pick < 4) ? ROWCNT_W'(MAX_ROWS) : ROWCNT_W'($urandom_range(1, 5));
    return c;
  endfunction

  // Gaps before a word: mostly none, some short, a few long
  function automatic int sender_gap();
    int pick;
    if (!sender_idles) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the predicted detector by one accepted pixel word
  task automatic judge_pixel(input pixel_t px, output bit used, output bit done,
                             output frame_report_t res);
    int gray;
    bit bright;
    used = int'(row_now) >= int'(live_cfg.first_row) &&
           int'(row_now) - int'(live_cfg.first_row) < int'(live_cfg.row_count);
    done = px.frame_end;
    res  = '0;
    gray = (int'(px.red) * 4899 + int'(px.green) * 9617 + int'(px.blue) * 1868 + 8192) >> 14;
    bright = gray > int'(live_cfg.thr);
    if (used) begin
      if (mask_ptr < MASK_PIXELS) begin
        if (bright && lit_now != COUNT_LIMIT) lit_now++;
        if (!first_frame_pending && bright != mask_copy[mask_ptr] && chg_now != COUNT_LIMIT)
          chg_now++;
        mask_copy[mask_ptr] = bright;
        mask_ptr++;
      end else begin
        ovf_now = 1'b1;
      end
    end
    if (px.frame_end) begin
      res.fire_found     = !first_frame_pending && lit_now > live_cfg.lit_min &&
                           chg_now > live_cfg.chg_min;
      res.lit_pixels     = lit_now;
      res.changed_pixels = chg_now;
      res.store_overflow = ovf_now;
      first_frame_pending = 1'b0;
      row_now  = '0;
      mask_ptr = 0;
      lit_now  = '0;
      chg_now  = '0;
      ovf_now  = 1'b0;
    end else if (px.line_end && row_now != ROW_LAST) begin
      row_now++;
    end
  endtask

  // Offer one word, hold it until taken, then book the report it owes.
  // Valid stays high between back-to-back words and is only lowered for a gap.
  task automatic send_pixel(input pixel_t px, input bit typed, input frame_report_t want);
    int gap;
    bit used;
    bit done;
    frame_report_t res;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {px.blue, px.green, px.red};
    in_tuser  <= px.line_end;
    in_tlast  <= px.frame_end;
    do begin
      @(posedge clk);
    end while (in_tready !== 1'b1);
    words_sent++;
    judge_pixel(px, used, done, res);
    if (used) band_words++;
    if (done) pending_reports.push_back(typed ? want : res);
  endtask

  // Drop valid and hold until every owed report has been taken
  task automatic wait_reports();
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_reports.size() != 0);
  endtask

  task automatic settle();
    wait_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back, then mirror them in the prediction
  task automatic apply_settings(input band_cfg_t c);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_GRAY_THRESHOLD;
    cfg_wr_data <= COUNT_W'(c.thr);
    @(posedge clk);
    cfg_index   <= REG_LIT_MINIMUM;
    cfg_wr_data <= c.lit_min;
    @(posedge clk);
    cfg_index   <= REG_CHANGE_MINIMUM;
    cfg_wr_data <= c.chg_min;
    @(posedge clk);
    cfg_index   <= REG_BAND_FIRST_ROW;
    cfg_wr_data <= COUNT_W'(c.first_row);
    @(posedge clk);
    cfg_index   <= REG_BAND_ROW_COUNT;
    cfg_wr_data <= COUNT_W'(c.row_count);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    live_cfg = c;
  endtask

  // Raster frame of random pixels; a stray line end now and then shortens a row
  task automatic send_random_frame(input int rows, input int max_width);
    int width;
    int r;
    int c;
    bit last_word;
    for (r = 0; r < rows; r++) begin
      width = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, max_width);
      for (c = 0; c < width; c++) begin
        last_word = (r == rows - 1) && (c == width - 1);
        send_pixel(noise_pixel(last_word ? bit'($urandom_range(0, 1)) :
                               (c == width - 1) || ($urandom_range(0, 19) == 0),
                               last_word),
                   1'b0, '0);
      end
    end
  endtask

  // Receiver: ready mostly high, with short stalls and the odd long one
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (receiver_stalls && $urandom_range(0, 7) == 0)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                 : $urandom_range(1, 3);
    end
  end

  // Compare each taken report word with the oldest one owed
  always @(posedge clk) begin : check_reports
    frame_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("report word with none owed: tdata %h tuser %b", out_tdata, out_tuser);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_seen++;
        if (want.fire_found) fire_reports++;
        if (want.store_overflow) overflow_seen++;
        if (out_tuser[0] !== want.fire_found) begin
          $error("fire_found: expected %0d, got %0d", want.fire_found, out_tuser[0]);
          error_count++;
        end
        if (out_tdata[21:0] !== want.lit_pixels) begin
          $error("lit_pixels: expected %0d, got %0d", want.lit_pixels, out_tdata[21:0]);
          error_count++;
        end
        if (out_tdata[43:22] !== want.changed_pixels) begin
          $error("changed_pixels: expected %0d, got %0d", want.changed_pixels,
                 out_tdata[43:22]);
          error_count++;
        end
        if (out_tuser[1] !== want.store_overflow) begin
          $error("store_overflow: expected %0d, got %0d", want.store_overflow,
                 out_tuser[1]);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t  dir_rows [$];
    band_cfg_t dir_settings [4];
    int        cur_seg;
    int        band_idx;
    int        r;
    int        c;
    int        phase;
    int        frames;
    int        f;
    pixel_t    px;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill frame, first after reset and on reset settings: one-word rows above the band,
    // then a block of band rows (even band words white, odd black) whose last word ends
    // the frame. No later frame holds more band words than this, so none reads an
    // unwritten store entry.
    sender_idles = 1'b0;
    for (r = 0; r < int'(RST_BAND_FIRST_ROW); r++)
      send_pixel(noise_pixel(1'b1, 1'b0), 1'b0, '0);
    band_idx = 0;
    for (r = 0; r < FILL_ROWS; r++) begin
      for (c = 0; c < FILL_WIDTH; c++) begin
        if (band_idx % 2 == 0)
          px = pixel(255, 255, 255, c == FILL_WIDTH - 1, band_idx == FILL_WORDS - 1);
        else
          px = pixel(0, 0, 0, c == FILL_WIDTH - 1, band_idx == FILL_WORDS - 1);
        send_pixel(px, band_idx == FILL_WORDS - 1, report(1'b0, FILL_WORDS / 2, 0, 1'b0));
        band_idx++;
      end
    end

    // Directed table. Typed reports only where the value is plain to see.
    sender_idles = 1'b1;
    // threshold 0, zero minimums, band = row 0 alone
    dir_settings[0] = settings(0, 0, 0, 0, 1);
    // threshold at its maximum, minimums at the store depth, band at the last row and widest
    dir_settings[1] = settings(255, MASK_PIXELS, MASK_PIXELS, MAX_ROWS - 1, MAX_ROWS);
    // empty band
    dir_settings[2] = settings(254, 0, 0, 0, 0);
    // band = rows 1 and 2, threshold one below full scale
    dir_settings[3] = settings(254, 0, 0, 1, 2);

    // one-word frames at address 0: black after a white fill bit, then gray 0, gray 1
    dir_rows.push_back(dir_row(0, pixel(0, 0, 0, 0, 1), 1'b1, report(0, 0, 1, 0)));
    dir_rows.push_back(dir_row(0, pixel(1, 0, 0, 0, 1), 1'b1, report(0, 0, 0, 0)));
    dir_rows.push_back(dir_row(0, pixel(0, 1, 0, 0, 1), 1'b1, report(1, 1, 1, 0)));
    // multi-row frame, only row 0 in the band
    dir_rows.push_back(dir_row(0, pixel(255, 255, 255, 0, 0), 1'b0, '0));
    dir_rows.push_back(dir_row(0, pixel(255, 0, 0, 1, 0), 1'b0, '0));
    dir_rows.push_back(dir_row(0, pixel(0, 0, 255, 1, 0), 1'b0, '0));
    dir_rows.push_back(dir_row(0, pixel(12, 34, 56, 0, 1), 1'b0, '0));
    // band far below the frame: nothing counted
    dir_rows.push_back(dir_row(1, pixel(255, 255, 255, 1, 0), 1'b0, '0));
    dir_rows.push_back(dir_row(1, pixel(255, 255, 255, 1, 1), 1'b1, report(0, 0, 0, 0)));
    // empty band: nothing counted
    dir_rows.push_back(dir_row(2, pixel(255, 255, 255, 0, 0), 1'b0, '0));
    dir_rows.push_back(dir_row(2, pixel(255, 255, 255, 1, 1), 1'b1, report(0, 0, 0, 0)));
    // two-row band, gray exactly at and just above the threshold
    dir_rows.push_back(dir_row(3, pixel(255, 255, 255, 1, 0), 1'b0, '0));
    dir_rows.push_back(dir_row(3, pixel(255, 255, 255, 0, 0), 1'b0, '0));
    dir_rows.push_back(dir_row(3, pixel(254, 254, 254, 1, 0), 1'b0, '0));
    dir_rows.push_back(dir_row(3, pixel(0, 0, 0, 1, 0), 1'b0, '0));
    dir_rows.push_back(dir_row(3, pixel(255, 255, 255, 1, 1), 1'b0, '0));

    cur_seg = -1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].seg != cur_seg) begin
        settle();
        apply_settings(dir_settings[dir_rows[i].seg]);
        cur_seg = dir_rows[i].seg;
      end
      send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases: fresh settings each time, short frames with random content
    band_words = 0;
    phase = 0;
    while (words_sent < TOTAL_WORDS) begin
      settle();
      apply_settings(random_settings());
      sender_idles    = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      frames = $urandom_range(3, 8);
      for (f = 0; f < frames; f++) begin
        // in the second phase, hold input before each frame until all owed reports are taken
        if (phase == 1) wait_reports();
        send_random_frame($urandom_range(1, 6), 10);
      end
      phase++;
    end

    settle();
    $display("Covered %0d frame reports (%0d with fire, %0d with store overflow),",
             reports_seen, fire_reports, overflow_seen);
    $display("%0d pixel words in all, %0d of them band words in the random phases.",
             words_sent, band_words);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Generous cap: a correct run needs well under 2 ms even with the longest gaps and stalls
  initial begin : watchdog
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
